>>> design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/tcw_pkg.sv
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int PROD_W = ROW_W + COL_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // operation codes of an input item
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_ATTR = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'hF0;

  // command kinds after classification
  localparam logic [2:0] KIND_NOP     = 3'd0;
  localparam logic [2:0] KIND_PUT     = 3'd1;
  localparam logic [2:0] KIND_NEWLINE = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic              cell_written;
    logic              did_scroll;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cols;
    logic [ROW_W-1:0]  rows;
    logic [ATTR_W-1:0] attr;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> design/text_console_writer.sv
// channel | ports                                   | direction
// --------+-----------------------------------------+----------
// input   | in_valid, in_stall, in_item             | item in, stall out
// result  | out_valid, out_stall, out_item          | item out, stall in
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write in, ready out
//
// engine steps: put S_PUT_MUL, S_PUT_WR; read S_RD_MUL, S_RD_ADDR, S_RD_OUT, set by the
// shared row*cols multiplier and the registered store read; newline, unused code and
// off-screen read are answered from S_IDLE; an item passes the decoder register and a queue
// slot before the engine; a scrolling put sweeps rows*cols cells, one cell a cycle
// through the single store write port; clear blanks all MAX_COLS*MAX_ROWS cells; after reset
// the store is blanked one cell a cycle, in_stall high until done; a two-item queue sits
// between decoder and engine; the engine takes no item while a result waits on out_stall
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // reset geometry is the full store, as far as the register widths reach
  localparam logic [COL_W-1:0] COLS_RST = (MAX_COLS > 127) ? '1 : COL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] ROWS_RST = (MAX_ROWS > 31) ? '1 : ROW_W'(MAX_ROWS);

  cfg_t      cfg_r;
  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head_cmd;
  logic      init_busy;

  // config writes are always taken; the user must change geometry only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols <= COLS_RST;
      cfg_r.rows <= ROWS_RST;
      cfg_r.attr <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLS: cfg_r.cols <= cfg_data[COL_W-1:0];
        CFG_ROWS: cfg_r.rows <= cfg_data[ROW_W-1:0];
        CFG_ATTR: cfg_r.attr <= cfg_data;
        default: begin
          // unused index, ignored
        end
      endcase
    end
  end

  // front: takes items and decodes them into commands
  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .init_busy (init_busy),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // short command queue so decode and execution stall on their own
  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_status (q_status),
    .head_cmd (head_cmd)
  );

  // back: cursor, screen store, scroll and clear sweeps, result register
  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a written cell always leaves the cursor past column 0
  `ASSERT_IMPLIES(a_write_advances, clk, rst_n, out_valid && out_item.cell_written, out_item.cursor_col_out != '0, "put wrote a cell without advancing")
  // only a put that writes can scroll
  `ASSERT_IMPLIES(a_scroll_writes, clk, rst_n, out_valid && out_item.did_scroll, out_item.cell_written, "scroll without a cell write")
  // no item is taken while the store is still being blanked
  `ASSERT_IMPLIES(a_init_stalls, clk, rst_n, init_busy, in_stall, "item taken during store blanking")
  // the blanking pass after reset gives no result
  `ASSERT_NEXT(a_init_quiet, clk, rst_n, init_busy, !out_valid, "result during store blanking")

endmodule

>>> design/tcw_front.sv
module tcw_front import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  logic      init_busy,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      push_cmd
);

  logic cmd_valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  assign push     = cmd_valid_r && !q_status.full;
  assign in_stall = init_busy || (cmd_valid_r && q_status.full);
  assign accept   = in_valid && !in_stall;
  assign push_cmd = cmd_r;

  // decode the operation into a command kind
  always_comb begin
    cmd_nxt.char_code = in_item.char_code;
    cmd_nxt.read_row  = in_item.read_row;
    cmd_nxt.read_col  = in_item.read_col;
    case (in_item.operation)
      OP_PUT: begin
        cmd_nxt.kind = (in_item.char_code == CHAR_NEWLINE) ? KIND_NEWLINE : KIND_PUT;
      end
      OP_READ:  cmd_nxt.kind = KIND_READ;
      OP_CLEAR: cmd_nxt.kind = KIND_CLEAR;
      default:  cmd_nxt.kind = KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (accept) begin
      cmd_valid_r <= 1'b1;
    end else if (push) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

>>> design/tcw_queue.sv
module tcw_queue import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output q_status_t q_status,
  output cmd_t      head_cmd
);

  cmd_t               slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_nxt;

  assign q_status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head_cmd       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_status_t q_status,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      init_busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int CMP_W      = ((CNT_W > PROD_W) ? CNT_W : PROD_W) + 1;
  localparam logic [COL_W-1:0] COLS_CAP = (MAX_COLS > 127) ? '1 : COL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] ROWS_CAP = (MAX_ROWS > 31) ? '1 : ROW_W'(MAX_ROWS);

  localparam logic [3:0] S_FILL     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_RD_MUL   = 4'd2;
  localparam logic [3:0] S_RD_ADDR  = 4'd3;
  localparam logic [3:0] S_RD_OUT   = 4'd4;
  localparam logic [3:0] S_PUT_MUL  = 4'd5;
  localparam logic [3:0] S_PUT_WR   = 4'd6;
  localparam logic [3:0] S_SC_MUL   = 4'd7;
  localparam logic [3:0] S_SC_COPY  = 4'd8;
  localparam logic [3:0] S_SC_BLANK = 4'd9;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [3:0]        state_r,      state_nxt;
  logic [CNT_W-1:0]  idx_r,        idx_nxt;
  logic              init_r,       init_nxt;
  logic              clr_item_r,   clr_item_nxt;
  logic [ROW_W-1:0]  mul_a_r,      mul_a_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [ROW_W-1:0]  cur_row_r,    cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r,    cur_col_nxt;
  logic [CHAR_W-1:0] char_r,       char_nxt;
  logic [COL_W-1:0]  col_hold_r,   col_hold_nxt;
  logic              scroll_r,     scroll_nxt;
  logic              wr_en_r,      wr_en_nxt;
  logic              wr_from_mem_r, wr_from_mem_nxt;
  logic [ADDR_W-1:0] wr_addr_r,    wr_addr_nxt;
  logic [CELL_W-1:0] wr_data_r,    wr_data_nxt;
  logic [CELL_W-1:0] rdata_r;
  logic              out_valid_r,  out_valid_nxt;
  out_item_t         out_item_r,   out_item_nxt;

  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  cols_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic              out_free;
  logic              col_wrap;
  logic [ROW_W-1:0]  row_w;
  logic [COL_W-1:0]  col_w;
  logic [CMP_W-1:0]  src_c;
  logic [CMP_W-1:0]  idx_c;
  logic [CMP_W-1:0]  total_c;
  logic [CELL_W-1:0] blank_cell;

  // geometry clamped to the store
  always_comb begin
    if (cfg.cols == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(cfg.cols) > MAX_COLS) begin
      cols_eff = COLS_CAP;
    end else begin
      cols_eff = cfg.cols;
    end
    if (cfg.rows == '0) begin
      rows_eff = ROW_W'(1);
    end else if (int'(cfg.rows) > MAX_ROWS) begin
      rows_eff = ROWS_CAP;
    end else begin
      rows_eff = cfg.rows;
    end
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign blank_cell = {cfg.attr, CHAR_BLANK};
  assign col_wrap   = (cur_col_r >= cols_eff);
  assign row_w      = (col_wrap && (cur_row_r < rows_eff)) ? cur_row_r + 1'b1 : cur_row_r;
  assign col_w      = col_wrap ? '0 : cur_col_r;
  assign idx_c      = CMP_W'(idx_r);
  assign src_c      = CMP_W'(idx_r) + CMP_W'(cols_eff);
  assign total_c    = CMP_W'(prod_r);

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    init_nxt        = init_r;
    clr_item_nxt    = clr_item_r;
    mul_a_nxt       = mul_a_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    char_nxt        = char_r;
    col_hold_nxt    = col_hold_r;
    scroll_nxt      = scroll_r;
    wr_en_nxt       = 1'b0;
    wr_from_mem_nxt = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    wr_data_nxt     = wr_data_r;
    rd_addr         = '0;
    pop             = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_item_nxt    = out_item_r;

    case (state_r)
      S_FILL: begin
        if (idx_r == CNT_W'(CELL_COUNT)) begin
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
          if (clr_item_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end
        end else begin
          wr_en_nxt   = 1'b1;
          wr_addr_nxt = idx_r[ADDR_W-1:0];
          wr_data_nxt = blank_cell;
          idx_nxt     = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop = 1'b1;
          out_item_nxt                = '0;
          out_item_nxt.cursor_row_out = cur_row_r;
          out_item_nxt.cursor_col_out = cur_col_r;
          case (head_cmd.kind)
            KIND_NEWLINE: begin
              cur_col_nxt = '0;
              if (cur_row_r < rows_eff) begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
              out_valid_nxt               = 1'b1;
              out_item_nxt.cursor_row_out = cur_row_nxt;
              out_item_nxt.cursor_col_out = '0;
            end
            KIND_READ: begin
              if ((head_cmd.read_row < rows_eff) && (head_cmd.read_col < cols_eff)) begin
                mul_a_nxt    = head_cmd.read_row;
                col_hold_nxt = head_cmd.read_col;
                state_nxt    = S_RD_MUL;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            KIND_CLEAR: begin
              cur_row_nxt  = '0;
              cur_col_nxt  = '0;
              idx_nxt      = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = S_FILL;
            end
            KIND_PUT: begin
              cur_row_nxt = row_w;
              cur_col_nxt = col_w;
              char_nxt    = head_cmd.char_code;
              if (row_w >= rows_eff) begin
                scroll_nxt = 1'b1;
                mul_a_nxt  = rows_eff;
                state_nxt  = S_SC_MUL;
              end else begin
                scroll_nxt = 1'b0;
                mul_a_nxt  = row_w;
                state_nxt  = S_PUT_MUL;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_RD_MUL: state_nxt = S_RD_ADDR;

      S_RD_ADDR: begin
        rd_addr   = ADDR_W'(prod_r + PROD_W'(col_hold_r));
        state_nxt = S_RD_OUT;
      end

      S_RD_OUT: begin
        out_valid_nxt               = 1'b1;
        out_item_nxt                = '0;
        out_item_nxt.cell_value     = rdata_r;
        out_item_nxt.cursor_row_out = cur_row_r;
        out_item_nxt.cursor_col_out = cur_col_r;
        state_nxt                   = S_IDLE;
      end

      S_PUT_MUL: state_nxt = S_PUT_WR;

      S_PUT_WR: begin
        wr_en_nxt                   = 1'b1;
        wr_addr_nxt                 = ADDR_W'(prod_r + PROD_W'(cur_col_r));
        wr_data_nxt                 = {cfg.attr, char_r};
        cur_col_nxt                 = cur_col_r + 1'b1;
        out_valid_nxt               = 1'b1;
        out_item_nxt.cell_value     = {cfg.attr, char_r};
        out_item_nxt.cell_written   = 1'b1;
        out_item_nxt.did_scroll     = scroll_r;
        out_item_nxt.cursor_row_out = cur_row_r;
        out_item_nxt.cursor_col_out = cur_col_nxt;
        state_nxt                   = S_IDLE;
      end

      S_SC_MUL: begin
        idx_nxt   = '0;
        state_nxt = S_SC_COPY;
      end

      S_SC_COPY: begin
        if (src_c >= total_c) begin
          state_nxt = S_SC_BLANK;
        end else begin
          rd_addr         = ADDR_W'(src_c);
          wr_en_nxt       = 1'b1;
          wr_from_mem_nxt = 1'b1;
          wr_addr_nxt     = idx_r[ADDR_W-1:0];
          idx_nxt         = idx_r + 1'b1;
        end
      end

      S_SC_BLANK: begin
        if (idx_c >= total_c) begin
          cur_row_nxt = rows_eff - 1'b1;
          cur_col_nxt = '0;
          mul_a_nxt   = rows_eff - 1'b1;
          state_nxt   = S_PUT_MUL;
        end else begin
          wr_en_nxt   = 1'b1;
          wr_addr_nxt = idx_r[ADDR_W-1:0];
          wr_data_nxt = blank_cell;
          idx_nxt     = idx_r + 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      idx_r       <= '0;
      init_r      <= 1'b1;
      clr_item_r  <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      init_r      <= init_nxt;
      clr_item_r  <= clr_item_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      wr_en_r     <= wr_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r       <= mul_a_nxt;
    prod_r        <= PROD_W'(mul_a_r) * PROD_W'(cols_eff);
    char_r        <= char_nxt;
    col_hold_r    <= col_hold_nxt;
    scroll_r      <= scroll_nxt;
    wr_from_mem_r <= wr_from_mem_nxt;
    wr_addr_r     <= wr_addr_nxt;
    wr_data_r     <= wr_data_nxt;
    out_item_r    <= out_item_nxt;
  end

  // screen store: one write port fed by the write stage, one registered read
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[wr_addr_r] <= wr_from_mem_r ? rdata_r : wr_data_r;
    end
    rdata_r <= mem[rd_addr];
  end

endmodule

>>> tb/tcw_checker.sv
`timescale 1ns / 1ps
module tcw_checker import tcw_pkg::*; #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         outstanding,
  output int         failures
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

  logic [CELL_W-1:0] cells [CELL_COUNT];
  int                crow;
  int                ccol;
  logic [COL_W-1:0]  cols_reg;
  logic [ROW_W-1:0]  rows_reg;
  logic [ATTR_W-1:0] attr_reg;
  out_item_t         reply_q [$];
  int                mismatch_count = 0;

  assign failures = mismatch_count;

  function automatic int eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic int eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) cells[i] = {attr_reg, CHAR_BLANK};
  endfunction

  // rows move up one, bottom row blanked, cursor to start of last row
  function automatic void shift_rows_up(int nc, int nr);
    for (int r = 1; r < nr; r++)
      for (int c = 0; c < nc; c++) cells[(r - 1) * nc + c] = cells[r * nc + c];
    for (int c = 0; c < nc; c++) cells[(nr - 1) * nc + c] = {attr_reg, CHAR_BLANK};
    crow = nr - 1;
    ccol = 0;
  endfunction

  function automatic out_item_t console_step(in_item_t it);
    int        nc;
    int        nr;
    out_item_t res;
    nc  = eff_cols();
    nr  = eff_rows();
    res = '0;
    case (it.operation)
      OP_PUT: begin
        if (it.char_code == CHAR_NEWLINE) begin
          ccol = 0;
          if (crow < nr) crow++;
        end else begin
          if (ccol >= nc) begin
            ccol = 0;
            if (crow < nr) crow++;
          end
          if (crow >= nr) begin
            shift_rows_up(nc, nr);
            res.did_scroll = 1'b1;
          end
          res.cell_value           = {attr_reg, it.char_code};
          cells[crow * nc + ccol]  = res.cell_value;
          res.cell_written         = 1'b1;
          ccol++;
        end
      end
      OP_READ: begin
        if (int'(it.read_row) < nr && int'(it.read_col) < nc)
          res.cell_value = cells[int'(it.read_row) * nc + int'(it.read_col)];
      end
      OP_CLEAR: begin
        blank_screen();
        crow = 0;
        ccol = 0;
      end
      default: ;
    endcase
    res.cursor_row_out = crow[ROW_W-1:0];
    res.cursor_col_out = ccol[COL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_reply(out_item_t got, out_item_t want);
    if (got.cell_value !== want.cell_value)
      report_mismatch($sformatf("cell_value got %h want %h", got.cell_value, want.cell_value));
    if (got.cell_written !== want.cell_written)
      report_mismatch($sformatf("cell_written got %b want %b",
                                got.cell_written, want.cell_written));
    if (got.did_scroll !== want.did_scroll)
      report_mismatch($sformatf("did_scroll got %b want %b", got.did_scroll, want.did_scroll));
    if (got.cursor_row_out !== want.cursor_row_out)
      report_mismatch($sformatf("cursor_row_out got %0d want %0d",
                                got.cursor_row_out, want.cursor_row_out));
    if (got.cursor_col_out !== want.cursor_col_out)
      report_mismatch($sformatf("cursor_col_out got %0d want %0d",
                                got.cursor_col_out, want.cursor_col_out));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg = COL_W'(MAX_COLS);
      rows_reg = ROW_W'(MAX_ROWS);
      attr_reg = ATTR_RESET;
      crow     = 0;
      ccol     = 0;
      blank_screen();
      reply_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLS: cols_reg = cfg_data[COL_W-1:0];
          CFG_ROWS: rows_reg = cfg_data[ROW_W-1:0];
          CFG_ATTR: attr_reg = cfg_data[ATTR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) reply_q.push_back(console_step(in_item));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) report_mismatch("result with nothing expected");
        else check_reply(out_item, reply_q.pop_front());
      end
    end
    outstanding <= reply_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tcw_pkg::*;

  localparam int MAX_COLS     = 80;
  localparam int MAX_ROWS     = 25;
  localparam int RANDOM_ITEMS = 1150;
  // settle time after the last result, a bit over one full-screen scroll or clear
  localparam int TAIL_CYCLES  = 2100;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_COLS;
  logic [7:0] cfg_data  = '0;

  int outstanding;
  int failures;

  // effective geometry as the console sees it, used to aim reads at the screen
  int cols_now = MAX_COLS;
  int rows_now = MAX_ROWS;

  // per-phase switches that turn off idling on one side
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;
  int hold_left = 0;
  int sent      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_writer #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tcw_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .failures    (failures)
  );

  // result-side backpressure: short bursts mostly, now and then a long stall
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      hold_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
    end
  end

  // source-side gap before an item: none half the time, a few short, rarely long
  function automatic int gap_cycles();
    int pick;
    if (quiet_in) return 0;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t item_of(logic [1:0] op, logic [7:0] ch,
                                       logic [4:0] row, logic [6:0] col);
    in_item_t it;
    it.operation = op;
    it.char_code = ch;
    it.read_row  = row;
    it.read_col  = col;
    return it;
  endfunction

  // mostly puts of random bytes and newlines, plus reads, clears and the unused code
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.operation = OP_PUT;
    it.char_code = CHAR_W'($urandom_range(0, 255));
    it.read_row  = ROW_W'($urandom_range(0, 31));
    it.read_col  = COL_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.char_code = CHAR_NEWLINE;
    end else if (pick < 24) begin
      // reads that land on the visible screen
      it.operation = OP_READ;
      it.read_row  = ROW_W'($urandom_range(0, rows_now - 1));
      it.read_col  = COL_W'($urandom_range(0, cols_now - 1));
    end else if (pick < 28) begin
      // reads anywhere the fields reach, often off screen
      it.operation = OP_READ;
    end else if (pick < 30) begin
      it.operation = OP_CLEAR;
    end else if (pick < 33) begin
      it.operation = OP_SPARE;
    end
    return it;
  endfunction

  // holds valid high straight into the next item when there is no gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // leaves cfg_valid high so back-to-back writes follow without a gap
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes all three registers and mirrors the geometry the console will use
  task automatic program_console(logic [7:0] c, logic [7:0] r, logic [7:0] a, bit spare);
    write_reg(CFG_COLS, c);
    write_reg(CFG_ROWS, r);
    write_reg(CFG_ATTR, a);
    if (spare) write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    cols_now = (c[6:0] == 0) ? 1 : ((c[6:0] > MAX_COLS) ? MAX_COLS : c[6:0]);
    rows_now = (r[4:0] == 0) ? 1 : ((r[4:0] > MAX_ROWS) ? MAX_ROWS : r[4:0]);
  endtask

  // column count: extremes and out-of-range values now and then, small screens mostly
  function automatic logic [7:0] pick_cols();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0:       v = 8'd0;
      1:       v = 8'd1;
      2:       v = 8'(MAX_COLS);
      3:       v = 8'($urandom_range(MAX_COLS + 1, 127));
      default: v = 8'($urandom_range(2, 12));
    endcase
    v[7] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic logic [7:0] pick_rows();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0:       v = 8'd0;
      1:       v = 8'd1;
      2:       v = 8'(MAX_ROWS);
      3:       v = 8'($urandom_range(MAX_ROWS + 1, 31));
      default: v = 8'($urandom_range(2, 5));
    endcase
    v[7:5] = 3'($urandom_range(0, 7));
    return v;
  endfunction

  function automatic logic [7:0] pick_attr();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int phase;
    int n_items;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: corner reads, off-screen reads, byte extremes, newline,
    // the unused code and a clear
    send_item(item_of(OP_READ, 8'h00, 5'd0, 7'd0));
    send_item(item_of(OP_READ, 8'hFF, 5'd24, 7'd79));
    send_item(item_of(OP_READ, 8'h00, 5'd25, 7'd0));
    send_item(item_of(OP_READ, 8'h00, 5'd0, 7'd80));
    send_item(item_of(OP_READ, 8'h00, 5'd31, 7'd127));
    send_item(item_of(OP_PUT, 8'h48, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, 8'hFF, 5'd31, 7'd127));
    send_item(item_of(OP_PUT, 8'h00, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, CHAR_NEWLINE, 5'd0, 7'd0));
    send_item(item_of(OP_SPARE, 8'h41, 5'd0, 7'd0));
    send_item(item_of(OP_READ, 8'h00, 5'd0, 7'd1));
    send_item(item_of(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    drain();

    // 2x2 screen: wrap at end of row, scroll from a wrap, newline run at the
    // bottom leaving one row pending, then the scroll it causes
    program_console(8'd2, 8'd2, 8'h00, 1'b0);
    send_item(item_of(OP_PUT, 8'h61, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, 8'h62, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, 8'h63, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, 8'h64, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, 8'h65, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, CHAR_NEWLINE, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, CHAR_NEWLINE, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, CHAR_NEWLINE, 5'd0, 7'd0));
    send_item(item_of(OP_PUT, 8'h66, 5'd0, 7'd0));
    send_item(item_of(OP_READ, 8'h00, 5'd1, 7'd0));
    send_item(item_of(OP_READ, 8'h00, 5'd0, 7'd1));
    drain();

    // random phases; the first few pin the geometry extremes, and the cursor
    // is carried over so a shrunk screen leaves it outside
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       program_console(8'd0, 8'd0, 8'hFF, 1'b1);
        1:       program_console(8'd127, 8'd31, 8'h00, 1'b0);
        2:       program_console(8'd1, 8'(MAX_ROWS), pick_attr(), 1'b0);
        3:       program_console(8'(MAX_COLS), 8'd1, pick_attr(), 1'b0);
        default: program_console(pick_cols(), pick_rows(), pick_attr(),
                                 $urandom_range(0, 19) == 0);
      endcase
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      n_items   = $urandom_range(15, 80);
      repeat (n_items) begin
        send_item(random_item());
        sent++;
      end
      drain();
      phase++;
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("text_console_writer test passed");
    else
      $display("text_console_writer test failed");
    $finish;
  end

  // generous bound: every item a full-screen scroll behind the longest gap and stall
  initial begin
    #100_000_000;
    $display("text_console_writer test failed");
    $finish;
  end

endmodule
